// ----- rtl/bds_pkg.sv -----
// Shared constants, types and register codes of the 5x5 box downsampler.
package bds_pkg;

    // Widths fixed by the register and pixel formats
    localparam int CW      = 10;   // source column / width
    localparam int RW      = 12;   // source row / height
    localparam int PXW     = 8;    // one color channel
    localparam int NCH     = 3;    // red, green, blue
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Defaults for the top-level parameters
    localparam int MAX_OUT_WIDTH_DEF = 128;
    localparam int FACTOR_DEF        = 5;

    // Register reset values
    localparam logic [CW-1:0] WIDTH_RST  = CW'(350);
    localparam logic [RW-1:0] HEIGHT_RST = RW'(350);

    // Register select, taken from paddr[2]
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // Room for (block index + 2) * FACTOR
    typedef logic [CW+3:0] t_cext;
    typedef logic [RW+3:0] t_rext;

    // Position of one source pixel within the block grid
    typedef struct packed {
        logic [CW-1:0] bcol;      // block column index
        logic          bcol_ok;   // block column below the store depth
        logic          col_ph0;   // first pixel of a row segment
        logic          row_ph0;   // first row of a band
        logic          seg_end;   // last pixel of a row segment
        logic          in_rng;    // pixel lies in a whole output block
        logic          blk_last;  // bottom-right pixel of its block
        logic          eor;       // block is the last of its output row
        logic          eof;       // block is the last of the frame
    } t_pos;

endpackage

// ----- rtl/bds_cfg.sv -----
// Configuration registers of the box downsampler behind an APB-style port.
module bds_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bds_pkg::PADDR_W-1:0]  paddr,
    input  logic [bds_pkg::PDATA_W-1:0]  pwdata,
    output logic [bds_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output logic [bds_pkg::CW-1:0]       o_src_width,
    output logic [bds_pkg::RW-1:0]       o_src_height
);

    logic [bds_pkg::CW-1:0] r_width;
    logic [bds_pkg::RW-1:0] r_height;
    logic                   wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= bds_pkg::WIDTH_RST;
            r_height <= bds_pkg::HEIGHT_RST;
        end else if (wr_en) begin
            case (paddr[2])
                bds_pkg::REG_WIDTH:  r_width  <= pwdata[bds_pkg::CW-1:0];
                bds_pkg::REG_HEIGHT: r_height <= pwdata[bds_pkg::RW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            bds_pkg::REG_WIDTH:
                prdata = {{(bds_pkg::PDATA_W-bds_pkg::CW){1'b0}}, r_width};
            bds_pkg::REG_HEIGHT:
                prdata = {{(bds_pkg::PDATA_W-bds_pkg::RW){1'b0}}, r_height};
            default:
                prdata = '0;
        endcase
    end

    assign o_src_width  = r_width;
    assign o_src_height = r_height;

endmodule

// ----- rtl/bds_pos.sv -----
// Source position counters and block-grid flags for the next input pixel.
module bds_pos #(
    parameter int MAX_OUT_WIDTH = bds_pkg::MAX_OUT_WIDTH_DEF,
    parameter int FACTOR        = bds_pkg::FACTOR_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_adv,
    input  logic [bds_pkg::CW-1:0] i_src_width,
    input  logic [bds_pkg::RW-1:0] i_src_height,
    output bds_pkg::t_pos          o_pos
);

    localparam int PH_W = $clog2(FACTOR);
    localparam logic [PH_W-1:0] PH_LAST = PH_W'(FACTOR - 1);
    localparam int CW = bds_pkg::CW;
    localparam int RW = bds_pkg::RW;

    logic [CW-1:0]   r_col,  n_col;
    logic [RW-1:0]   r_row,  n_row;
    logic [PH_W-1:0] r_cph,  n_cph;
    logic [PH_W-1:0] r_rph,  n_rph;
    logic [CW-1:0]   r_bcol, n_bcol;
    logic [RW-1:0]   r_brow, n_brow;

    logic [CW:0]     col_inc;
    logic [RW:0]     row_inc;
    logic            col_wrap;
    logic            row_wrap;
    bds_pkg::t_cext  c_end, c_nxt;
    bds_pkg::t_rext  r_end, r_nxt;
    logic            bcol_ok;
    logic            col_in, col_last;
    logic            row_in, row_last;

    assign col_inc  = {1'b0, r_col} + {{CW{1'b0}}, 1'b1};
    assign row_inc  = {1'b0, r_row} + {{RW{1'b0}}, 1'b1};
    assign col_wrap = col_inc >= {1'b0, i_src_width};
    assign row_wrap = row_inc >= {1'b0, i_src_height};

    // Block k covers columns up to (k+1)*FACTOR-1; it is whole if that end fits
    assign c_end = (bds_pkg::t_cext'(r_bcol) + bds_pkg::t_cext'(1))
                   * bds_pkg::t_cext'(FACTOR);
    assign c_nxt = c_end + bds_pkg::t_cext'(FACTOR);
    assign r_end = (bds_pkg::t_rext'(r_brow) + bds_pkg::t_rext'(1))
                   * bds_pkg::t_rext'(FACTOR);
    assign r_nxt = r_end + bds_pkg::t_rext'(FACTOR);

    assign bcol_ok  = bds_pkg::t_cext'(r_bcol) < bds_pkg::t_cext'(MAX_OUT_WIDTH);
    assign col_in   = bcol_ok && (c_end <= bds_pkg::t_cext'(i_src_width));
    assign col_last = (bds_pkg::t_cext'(r_bcol) + bds_pkg::t_cext'(1)
                       == bds_pkg::t_cext'(MAX_OUT_WIDTH))
                   || (c_nxt > bds_pkg::t_cext'(i_src_width));
    assign row_in   = r_end <= bds_pkg::t_rext'(i_src_height);
    assign row_last = r_nxt > bds_pkg::t_rext'(i_src_height);

    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        n_cph  = r_cph;
        n_rph  = r_rph;
        n_bcol = r_bcol;
        n_brow = r_brow;
        if (i_adv) begin
            if (col_wrap) begin
                n_col  = '0;
                n_cph  = '0;
                n_bcol = '0;
                if (row_wrap) begin
                    n_row  = '0;
                    n_rph  = '0;
                    n_brow = '0;
                end else begin
                    n_row = row_inc[RW-1:0];
                    if (r_rph == PH_LAST) begin
                        n_rph  = '0;
                        n_brow = r_brow + {{(RW-1){1'b0}}, 1'b1};
                    end else begin
                        n_rph = r_rph + {{(PH_W-1){1'b0}}, 1'b1};
                    end
                end
            end else begin
                n_col = col_inc[CW-1:0];
                if (r_cph == PH_LAST) begin
                    n_cph  = '0;
                    n_bcol = r_bcol + {{(CW-1){1'b0}}, 1'b1};
                end else begin
                    n_cph = r_cph + {{(PH_W-1){1'b0}}, 1'b1};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_cph  <= '0;
            r_rph  <= '0;
            r_bcol <= '0;
            r_brow <= '0;
        end else begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_cph  <= n_cph;
            r_rph  <= n_rph;
            r_bcol <= n_bcol;
            r_brow <= n_brow;
        end
    end

    always_comb begin
        o_pos          = '0;
        o_pos.bcol     = r_bcol;
        o_pos.bcol_ok  = bcol_ok;
        o_pos.col_ph0  = (r_cph == '0);
        o_pos.row_ph0  = (r_rph == '0);
        // a segment also ends early when the row wraps short of a block edge
        o_pos.seg_end  = (r_cph == PH_LAST) || col_wrap;
        o_pos.in_rng   = col_in && row_in;
        o_pos.blk_last = (r_cph == PH_LAST) && (r_rph == PH_LAST);
        o_pos.eor      = col_last;
        o_pos.eof      = col_last && row_last;
    end

endmodule

// ----- rtl/bds_accum.sv -----
// Pixel input register, band sum store, block average and result register.
module bds_accum #(
    parameter int MAX_OUT_WIDTH = bds_pkg::MAX_OUT_WIDTH_DEF,
    parameter int FACTOR        = bds_pkg::FACTOR_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  bds_pkg::t_pos           i_pos,
    input  logic [bds_pkg::PXW-1:0] i_red_in,
    input  logic [bds_pkg::PXW-1:0] i_green_in,
    input  logic [bds_pkg::PXW-1:0] i_blue_in,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [bds_pkg::PXW-1:0] o_red_out,
    output logic [bds_pkg::PXW-1:0] o_green_out,
    output logic [bds_pkg::PXW-1:0] o_blue_out,
    output logic                    o_end_of_row,
    output logic                    o_end_of_frame
);

    localparam int PXW    = bds_pkg::PXW;
    localparam int NCH    = bds_pkg::NCH;
    localparam int AREA   = FACTOR * FACTOR;
    localparam int SW     = $clog2(AREA * 255 + 1);
    localparam int AW     = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;
    // sum / AREA as (sum * RECIP) >> SHIFT, exact for every SW-bit sum
    localparam int SHIFT  = SW + $clog2(AREA);
    localparam int MW     = SW + 2;
    localparam int PW     = SW + MW;
    localparam logic [MW-1:0] RECIP = MW'(((1 << SHIFT) + AREA - 1) / AREA);

    logic [NCH-1:0][SW-1:0]  r_mem [MAX_OUT_WIDTH];

    logic                    r_in_valid;
    bds_pkg::t_pos           r_pos;
    logic [NCH-1:0][PXW-1:0] r_px;
    logic [NCH-1:0][SW-1:0]  r_rd;
    logic [NCH-1:0][SW-1:0]  r_hsum;
    logic                    r_seg_any;
    logic                    r_fresh;
    logic                    r_out_valid;
    logic [NCH-1:0][PXW-1:0] r_out_px;
    logic                    r_eor;
    logic                    r_eof;

    logic                    stage_go;
    logic                    accept;
    logic                    consume;
    logic                    emit;
    logic                    rd_en;
    logic                    wr_en;
    logic [AW-1:0]           rd_addr;
    logic [AW-1:0]           wr_addr;
    logic                    base_fresh;
    logic                    new_any;
    logic [NCH-1:0][SW-1:0]  new_hsum;
    logic [NCH-1:0][SW-1:0]  total;
    logic [NCH-1:0][PW-1:0]  prod;
    logic [NCH-1:0][PXW-1:0] quot;

    assign stage_go = !r_out_valid || i_ready;
    assign o_ready  = !r_in_valid || stage_go;
    assign accept   = i_valid && o_ready;
    assign consume  = r_in_valid && stage_go;

    assign emit     = r_pos.blk_last && r_pos.in_rng;
    assign rd_en    = accept && i_pos.col_ph0 && i_pos.bcol_ok;
    assign rd_addr  = i_pos.bcol[AW-1:0];
    assign wr_addr  = r_pos.bcol[AW-1:0];

    // Row segment: FACTOR pixels of one block on one row, summed here and
    // folded into the store once at the segment's end.
    always_comb begin
        base_fresh = r_pos.col_ph0 ? (r_pos.in_rng && r_pos.row_ph0) : r_fresh;
        new_any    = r_pos.in_rng || (!r_pos.col_ph0 && r_seg_any);
        for (int c = 0; c < NCH; c++) begin
            new_hsum[c] = (r_pos.col_ph0 ? '0 : r_hsum[c])
                        + (r_pos.in_rng ? SW'(r_px[c]) : '0);
            total[c]    = new_hsum[c] + (base_fresh ? '0 : r_rd[c]);
            prod[c]     = PW'(total[c]) * PW'(RECIP);
            quot[c]     = prod[c][SHIFT +: PXW];
        end
    end

    assign wr_en = consume && r_pos.seg_end && new_any;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= total;
        end
        if (rd_en) begin
            // bypass a write to the same entry in this cycle
            if (wr_en && (wr_addr == rd_addr)) begin
                r_rd <= total;
            end else begin
                r_rd <= r_mem[rd_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_seg_any   <= 1'b0;
            r_fresh     <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (stage_go) begin
                r_out_valid <= r_in_valid && emit;
            end
            if (consume) begin
                r_seg_any <= new_any;
                r_fresh   <= base_fresh;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pos   <= i_pos;
            r_px[0] <= i_red_in;
            r_px[1] <= i_green_in;
            r_px[2] <= i_blue_in;
        end
        if (consume) begin
            r_hsum <= new_hsum;
        end
        if (consume && emit) begin
            r_out_px <= quot;
            r_eor    <= r_pos.eor;
            r_eof    <= r_pos.eof;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_red_out      = r_out_px[0];
    assign o_green_out    = r_out_px[1];
    assign o_blue_out     = r_out_px[2];
    assign o_end_of_row   = r_eor;
    assign o_end_of_frame = r_eof;

    a_eof_has_eor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!o_end_of_frame || o_end_of_row))
        else $error("end of frame without end of row");

    a_emit_writes_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (consume && emit) |-> wr_en)
        else $error("block result without store update");

    a_emit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (consume && emit) |=> o_valid)
        else $error("block result not presented");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> o_ready)
        else $error("input stalled with empty input register");

endmodule

// ----- rtl/box_downsample_5x5_rgb_unit.sv -----
// Top level of the 5x5 box-filter downsampler for RGB pixel streams.
//
// Source pixels enter on i_valid/o_ready in raster order, one per cycle at
// full rate while the receiver keeps i_ready high. Each whole FACTOR x FACTOR
// block yields one averaged pixel (channel sum divided by FACTOR*FACTOR,
// truncated) on o_valid/i_ready, in raster order of the smaller image, with
// end-of-row and end-of-frame flags. Columns and rows outside whole blocks,
// and block columns at or past MAX_OUT_WIDTH, produce nothing.
// Throughput: one pixel per cycle while i_ready is high. A block's result
// passes through the input register and then the result register.
// Partial sums of a band sit in a MAX_OUT_WIDTH-entry store, one word of three
// channel sums per block column; a row segment is summed in registers and
// folded into the store in one read-modify-write at its end.
// The user must write source_width (address 0) and source_height (address 4)
// over the APB port only while the stream is idle; the block does not enforce
// this. pready is always high. Reset clears the position to the top-left pixel
// and empties both registers; the store needs no clearing. When the receiver
// stalls, the result register holds; o_ready drops while the input one is full.
module box_downsample_5x5_rgb_unit #(
    parameter int MAX_OUT_WIDTH = bds_pkg::MAX_OUT_WIDTH_DEF,
    parameter int FACTOR        = bds_pkg::FACTOR_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bds_pkg::PADDR_W-1:0] paddr,
    input  logic [bds_pkg::PDATA_W-1:0] pwdata,
    output logic [bds_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [bds_pkg::PXW-1:0]     i_red_in,
    input  logic [bds_pkg::PXW-1:0]     i_green_in,
    input  logic [bds_pkg::PXW-1:0]     i_blue_in,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [bds_pkg::PXW-1:0]     o_red_out,
    output logic [bds_pkg::PXW-1:0]     o_green_out,
    output logic [bds_pkg::PXW-1:0]     o_blue_out,
    output logic                        o_end_of_row,
    output logic                        o_end_of_frame
);

    logic [bds_pkg::CW-1:0] src_width;
    logic [bds_pkg::RW-1:0] src_height;
    bds_pkg::t_pos          pos;
    logic                   adv;

    assign adv = i_valid && o_ready;

    bds_cfg u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_src_width  (src_width),
        .o_src_height (src_height)
    );

    bds_pos #(
        .MAX_OUT_WIDTH (MAX_OUT_WIDTH),
        .FACTOR        (FACTOR)
    ) u_pos (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (adv),
        .i_src_width  (src_width),
        .i_src_height (src_height),
        .o_pos        (pos)
    );

    bds_accum #(
        .MAX_OUT_WIDTH (MAX_OUT_WIDTH),
        .FACTOR        (FACTOR)
    ) u_accum (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_pos          (pos),
        .i_red_in       (i_red_in),
        .i_green_in     (i_green_in),
        .i_blue_in      (i_blue_in),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_red_out      (o_red_out),
        .o_green_out    (o_green_out),
        .o_blue_out     (o_blue_out),
        .o_end_of_row   (o_end_of_row),
        .o_end_of_frame (o_end_of_frame)
    );

endmodule
